// File: rtl/core/ffsa_pkg.sv
`default_nettype none
package ffsa_pkg;
  typedef enum logic [1:0] {
    ACT_ALLOC = 2'd0,
    ACT_FREE  = 2'd1,
    ACT_CHECK = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_SHORT     = 3'd1,
    ST_NO_FIT    = 3'd2,
    ST_FULL      = 3'd3,
    ST_BAD_HANDLE = 3'd4,
    ST_SIZE_ZERO = 3'd5
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_SCAN_CHK,
    S_SPLIT_SHIFT,
    S_SPLIT_DONE,
    S_FREE_PREV,
    S_FREE_NEXT,
    S_REM_SHIFT,
    S_RESPOND
  } fsm_t;
endpackage
`default_nettype wire

// File: rtl/core/ffsa_if.sv
`default_nettype none
interface ffsa_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [10:0] request_size;
  logic [9:0]  handle_offset;
  modport source (output valid, action, request_size, handle_offset, input ready);
  modport sink (input valid, action, request_size, handle_offset, output ready);
endinterface

interface ffsa_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [9:0]  granted_offset;
  logic        fits;
  logic [10:0] free_total;
  modport source (output valid, status, granted_offset, fits, free_total, input ready);
  modport sink (input valid, status, granted_offset, fits, free_total, output ready);
endinterface
`default_nettype wire

// File: rtl/core/first_fit_segment_allocator_core.sv
// First-fit segment allocator with coalescing.
// Requests enter on req (action, request_size, handle_offset); one response
// per request leaves on rsp (status, granted_offset, fits, free_total).
// The segment table lives in one memory with a single write port and a
// registered read port; a small sequencer walks it entry by entry, a read
// then a check, to find a fit or a handle, and shifts entries one at a time
// to open a slot on a split or close one on a merge.
// Alloc and check requests with size zero, alloc requests beyond the free
// total and no-op requests answer without a scan.
// The block takes one request at a time; req.ready is high only when idle
// and no response is waiting.
// After reset the table holds one free segment covering all of memory; the
// table needs no clearing pass, since entries past the count are never used.
// A stalled receiver holds the response in the output register and the
// block waits until it is taken.
`default_nettype none
module first_fit_segment_allocator_core
  import ffsa_pkg::*;
#(
  parameter int MEMORY_UNITS = 1024,
  parameter int MAX_SEGMENTS = 64
) (
  input  wire logic clk,
  input  wire logic rst,
  ffsa_req_if.sink   req,
  ffsa_rsp_if.source rsp
);
  localparam int IW = $clog2(MAX_SEGMENTS);
  localparam int CW = $clog2(MAX_SEGMENTS + 1);
  localparam int AW = 10;
  localparam int LW = 11;

  // Table memory: start, length, used packed in one word.
  localparam int EW = AW + LW + 1;
  logic [EW-1:0] mem [MAX_SEGMENTS];
  logic [EW-1:0] rd_data;
  logic [IW-1:0] rd_addr;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  logic [EW-1:0] wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  wire [AW-1:0] rd_start = rd_data[EW-1 -: AW];
  wire [LW-1:0] rd_len   = rd_data[LW:1];
  wire          rd_used  = rd_data[0];

  fsm_t state, state_next;
  logic [CW-1:0] count, count_next;
  logic [LW-1:0] free_units, free_units_next;
  logic          init_done, init_done_next;
  logic [1:0]    act;
  logic [LW-1:0] size;
  logic [AW-1:0] handle;
  logic [CW-1:0] idx, idx_next;      // scan position
  logic          phase, phase_next;  // 0 issue read, 1 data valid
  logic [CW-1:0] pos, pos_next;      // entry found
  logic [AW-1:0] f_start, f_start_next;
  logic [LW-1:0] f_len, f_len_next;
  logic [CW-1:0] k, k_next;          // shift pointer
  logic [LW-1:0] merged, merged_next;
  logic [AW-1:0] m_start, m_start_next;
  logic          o_valid, o_valid_next;
  logic [2:0]    o_status, o_status_next;
  logic [AW-1:0] o_granted, o_granted_next;
  logic          o_fits, o_fits_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= CW'(1);
      free_units <= LW'(MEMORY_UNITS);
      init_done <= 1'b0;
      o_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      free_units <= free_units_next;
      init_done <= init_done_next;
      o_valid <= o_valid_next;
    end
    if (req.valid && req.ready) begin
      act <= req.action;
      size <= req.request_size;
      handle <= req.handle_offset;
    end
    idx <= idx_next; phase <= phase_next; pos <= pos_next;
    f_start <= f_start_next; f_len <= f_len_next; k <= k_next;
    merged <= merged_next; m_start <= m_start_next;
    o_status <= o_status_next; o_granted <= o_granted_next; o_fits <= o_fits_next;
  end

  assign req.ready = (state == S_IDLE) && !o_valid && init_done;
  assign rsp.valid = o_valid;
  assign rsp.status = o_status;
  assign rsp.granted_offset = o_granted;
  assign rsp.fits = o_fits;
  assign rsp.free_total = free_units;

  always_comb begin
    state_next = state;
    count_next = count;
    free_units_next = free_units;
    init_done_next = 1'b1;
    idx_next = idx; phase_next = phase; pos_next = pos;
    f_start_next = f_start; f_len_next = f_len; k_next = k;
    merged_next = merged; m_start_next = m_start;
    o_valid_next = o_valid;
    o_status_next = o_status; o_granted_next = o_granted; o_fits_next = o_fits;
    rd_addr = idx[IW-1:0];
    wr_en = 1'b0;
    wr_addr = '0;
    wr_data = '0;
    if (o_valid && rsp.ready) o_valid_next = 1'b0;
    if (!init_done) begin
      // Entry 0 written once after reset; the rest are never used unwritten.
      wr_en = 1'b1;
      wr_data = {AW'(0), LW'(MEMORY_UNITS), 1'b0};
    end
    case (state)
      S_IDLE: begin
        if (req.valid && req.ready) begin
          o_status_next = ST_OK; o_granted_next = '0; o_fits_next = 1'b0;
          idx_next = '0; phase_next = 1'b0;
          state_next = S_SCAN;
          if (req.action == ACT_NONE) state_next = S_RESPOND;
          else if (req.action != ACT_FREE && req.request_size == '0) begin
            o_status_next = ST_SIZE_ZERO; state_next = S_RESPOND;
          end else if (req.action == ACT_ALLOC && free_units < req.request_size) begin
            o_status_next = ST_SHORT; state_next = S_RESPOND;
          end
        end
      end
      S_SCAN: begin
        if (idx >= count) begin
          o_status_next = (act == ACT_ALLOC) ? ST_NO_FIT :
                          (act == ACT_FREE) ? ST_BAD_HANDLE : ST_OK;
          state_next = S_RESPOND;
        end else begin
          rd_addr = idx[IW-1:0];
          state_next = S_SCAN_CHK;
        end
      end
      S_SCAN_CHK: begin
        if (act == ACT_FREE ? (rd_used && rd_start == handle)
                            : (!rd_used && rd_len >= size)) begin
          pos_next = idx; f_start_next = rd_start; f_len_next = rd_len;
          if (act == ACT_CHECK) begin
            o_fits_next = 1'b1; state_next = S_RESPOND;
          end else if (act == ACT_FREE) begin
            free_units_next = free_units + rd_len;
            merged_next = rd_len; m_start_next = rd_start;
            rd_addr = IW'(idx - CW'(1));
            state_next = S_FREE_PREV;
          end else if (rd_len > size) begin
            if (count >= CW'(MAX_SEGMENTS)) begin
              o_status_next = ST_FULL; state_next = S_RESPOND;
            end else begin
              k_next = count; phase_next = 1'b0; state_next = S_SPLIT_SHIFT;
            end
          end else begin
            wr_en = 1'b1; wr_addr = idx[IW-1:0];
            wr_data = {rd_start, rd_len, 1'b1};
            free_units_next = free_units - rd_len;
            o_granted_next = rd_start;
            state_next = S_RESPOND;
          end
        end else begin
          idx_next = idx + CW'(1);
          state_next = S_SCAN;
        end
      end
      S_SPLIT_SHIFT: begin
        // Move entries up one slot, from the top down, then write the remainder into pos+1.
        if (k == pos + CW'(1)) begin
          wr_en = 1'b1; wr_addr = k[IW-1:0];
          wr_data = {AW'(f_start + AW'(size)), LW'(f_len - size), 1'b0};
          state_next = S_SPLIT_DONE;
        end else if (!phase) begin
          rd_addr = IW'(k - CW'(1)); phase_next = 1'b1;
        end else begin
          wr_en = 1'b1; wr_addr = k[IW-1:0]; wr_data = rd_data;
          k_next = k - CW'(1); phase_next = 1'b0;
        end
      end
      S_SPLIT_DONE: begin
        wr_en = 1'b1; wr_addr = pos[IW-1:0];
        wr_data = {f_start, size, 1'b1};
        count_next = count + CW'(1);
        free_units_next = free_units - size;
        o_granted_next = f_start;
        state_next = S_RESPOND;
      end
      S_FREE_PREV: begin
        // rd_data holds entry pos-1 (meaningless when pos is 0).
        if (pos != '0 && !rd_used) begin
          merged_next = merged + rd_len; m_start_next = rd_start;
          pos_next = pos - CW'(1);
          k_next = pos;            // entry to remove
        end else begin
          k_next = '0;
        end
        rd_addr = IW'(pos + CW'(1));
        state_next = S_FREE_NEXT;
      end
      S_FREE_NEXT: begin
        // rd_data holds the entry after the original one.
        if (k != '0) begin
          // Previous merge pending: the entry after the original now sits two slots past pos.
          if (phase) begin
            idx_next = '0; phase_next = 1'b0;
          end
        end
        if (pos + CW'(1) + ((k != '0) ? CW'(1) : CW'(0)) < count && !rd_used) begin
          merged_next = merged + rd_len;
          // Remove both when both merge: the original and the next entry go in one shift.
          idx_next = (k != '0) ? CW'(2) : CW'(1);
        end else begin
          idx_next = (k != '0) ? CW'(1) : CW'(0);
        end
        wr_en = 1'b1; wr_addr = pos[IW-1:0];
        wr_data = {m_start, ((pos + CW'(1) + ((k != '0) ? CW'(1) : CW'(0)) < count
                   && !rd_used) ? LW'(merged + rd_len) : merged), 1'b0};
        // Remove idx entries starting at pos+1 by shifting down.
        k_next = pos + CW'(1); phase_next = 1'b0;
        state_next = S_REM_SHIFT;
      end
      S_REM_SHIFT: begin
        // Copy entry k+idx into k until the end of the table.
        if (idx == '0 || k + idx >= count) begin
          count_next = count - idx;
          state_next = S_RESPOND;
        end else if (!phase) begin
          rd_addr = IW'(k + idx); phase_next = 1'b1;
        end else begin
          wr_en = 1'b1; wr_addr = k[IW-1:0]; wr_data = rd_data;
          k_next = k + CW'(1); phase_next = 1'b0;
        end
      end
      S_RESPOND: begin
        o_valid_next = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// File: rtl/core/ffsa_checker.sv
`default_nettype none
module ffsa_checker
  import ffsa_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        req_valid,
  input wire logic        req_ready,
  input wire logic        rsp_valid,
  input wire logic        rsp_ready,
  input wire logic [2:0]  status,
  input wire logic [10:0] free_total
);
  a_no_accept_with_pending: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !req_ready) else $error("request taken while response waits");
  a_rsp_held: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(status))
    else $error("response dropped under stall");
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> status <= ST_SIZE_ZERO) else $error("bad status code");
  a_free_bound: assert property (@(posedge clk) disable iff (rst)
    free_total <= 11'd1024) else $error("free total beyond memory");
endmodule

bind first_fit_segment_allocator_core ffsa_checker u_ffsa_checker (
  .clk(clk), .rst(rst), .req_valid(req.valid), .req_ready(req.ready),
  .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .status(rsp.status),
  .free_total(rsp.free_total)
);
`default_nettype wire

// File: verif/ffsa_scoreboard.sv
`timescale 1ns / 100ps
import ffsa_pkg::*;

typedef struct packed {
  status_t     status;
  logic [9:0]  granted_offset;
  logic        fits;
  logic [10:0] free_total;
} alloc_result_t;

class alloc_scoreboard;
  localparam int UNITS = 1024;
  localparam int SLOTS = 64;

  int unsigned seg_base [SLOTS];
  int unsigned seg_len [SLOTS];
  bit seg_busy [SLOTS];
  int unsigned seg_cnt;
  int unsigned units_free;
  alloc_result_t pending[$];
  int mismatches;

  function new();
    foreach (seg_base[i]) begin
      seg_base[i] = 0;
      seg_len[i] = 0;
      seg_busy[i] = 0;
    end
    seg_len[0] = UNITS;
    seg_cnt = 1;
    units_free = UNITS;
    mismatches = 0;
  endfunction

  function int first_fit(int unsigned size);
    for (int i = 0; i < seg_cnt; i++)
      if (!seg_busy[i] && seg_len[i] >= size) return i;
    return -1;
  endfunction

  function void drop_slot(int idx);
    for (int k = idx; k + 1 < seg_cnt; k++) begin
      seg_base[k] = seg_base[k + 1];
      seg_len[k] = seg_len[k + 1];
      seg_busy[k] = seg_busy[k + 1];
    end
    if (seg_cnt > 1) seg_cnt--;
  endfunction

  // Predicts the response for one accepted request and updates the table.
  function void note_request(action_t act, logic [10:0] size, logic [9:0] handle);
    alloc_result_t r;
    int pos;
    int i;
    r.status = ST_OK;
    r.granted_offset = 0;
    r.fits = 0;
    case (act)
      ACT_ALLOC: begin
        if (size == 0) r.status = ST_SIZE_ZERO;
        else if (units_free < size) r.status = ST_SHORT;
        else begin
          pos = first_fit(size);
          if (pos < 0) r.status = ST_NO_FIT;
          else begin
            if (seg_len[pos] > size) begin
              if (seg_cnt >= SLOTS) r.status = ST_FULL;
              else begin
                for (int k = seg_cnt; k > pos + 1; k--) begin
                  seg_base[k] = seg_base[k - 1];
                  seg_len[k] = seg_len[k - 1];
                  seg_busy[k] = seg_busy[k - 1];
                end
                seg_base[pos + 1] = seg_base[pos] + size;
                seg_len[pos + 1] = seg_len[pos] - size;
                seg_busy[pos + 1] = 0;
                seg_cnt++;
                seg_len[pos] = size;
              end
            end
            if (r.status == ST_OK) begin
              seg_busy[pos] = 1;
              units_free -= seg_len[pos];
              r.granted_offset = 10'(seg_base[pos]);
            end
          end
        end
      end
      ACT_FREE: begin
        pos = -1;
        for (i = 0; i < seg_cnt; i++)
          if (seg_busy[i] && seg_base[i] == handle) begin
            pos = i;
            break;
          end
        if (pos < 0) r.status = ST_BAD_HANDLE;
        else begin
          seg_busy[pos] = 0;
          units_free += seg_len[pos];
          if (pos > 0 && !seg_busy[pos - 1]) begin
            seg_len[pos - 1] += seg_len[pos];
            drop_slot(pos);
            pos--;
          end
          if (pos + 1 < seg_cnt && !seg_busy[pos + 1]) begin
            seg_len[pos] += seg_len[pos + 1];
            drop_slot(pos + 1);
          end
        end
      end
      ACT_CHECK: begin
        if (size == 0) r.status = ST_SIZE_ZERO;
        else r.fits = first_fit(size) >= 0;
      end
      default: ;
    endcase
    r.free_total = 11'(units_free);
    pending.push_back(r);
  endfunction

  // Returns a currently used segment start, or a random one when none exist.
  function logic [9:0] pick_handle();
    int idx[$];
    for (int i = 0; i < seg_cnt; i++)
      if (seg_busy[i]) idx.push_back(i);
    if (idx.size() == 0) return 10'($urandom_range(1023, 0));
    return 10'(seg_base[idx[$urandom_range(idx.size() - 1, 0)]]);
  endfunction

  function void check_response(alloc_result_t got);
    alloc_result_t want;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("Unexpected response %p", got);
      return;
    end
    want = pending.pop_front();
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("Mismatch: expected %p, got %p", want, got);
    end
  endfunction
endclass

// File: verif/testbench.sv
`timescale 1ns / 100ps
module testbench;
  import ffsa_pkg::*;

  logic clk = 0;
  logic rst = 1;
  ffsa_req_if req();
  ffsa_rsp_if rsp();
  alloc_scoreboard board = new();
  bit feeding_done = 0;

  first_fit_segment_allocator_core DUT (.clk(clk), .rst(rst), .req(req), .rsp(rsp));

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  function int gap_length();
    if ($urandom_range(9, 0) < 6) return 0;
    if ($urandom_range(9, 0) < 8) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  task automatic send_request(action_t act, logic [10:0] size, logic [9:0] handle);
    int gap;
    req.valid <= 1;
    req.action <= act;
    req.request_size <= size;
    req.handle_offset <= handle;
    do @(posedge clk); while (!req.ready);
    board.note_request(act, size, handle);
    gap = gap_length();
    // With no gap, valid stays high and the next request follows directly.
    if (gap > 0) begin
      req.valid <= 0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic random_request();
    int sel;
    sel = $urandom_range(99, 0);
    if (sel < 45) begin
      if ($urandom_range(9, 0) < 8) send_request(ACT_ALLOC, 11'($urandom_range(24, 1)), 0);
      else send_request(ACT_ALLOC, 11'($urandom_range(1024, 0)), 10'($urandom));
    end else if (sel < 80) begin
      if ($urandom_range(9, 0) < 8) send_request(ACT_FREE, 11'($urandom), board.pick_handle());
      else send_request(ACT_FREE, 11'($urandom), 10'($urandom));
    end else if (sel < 95) begin
      send_request(ACT_CHECK, 11'($urandom_range(2047, 0)), 10'($urandom));
    end else begin
      send_request(ACT_NONE, 11'($urandom), 10'($urandom));
    end
  endtask

  initial begin
    req.valid <= 0;
    req.action <= ACT_NONE;
    req.request_size <= 0;
    req.handle_offset <= 0;
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    send_request(ACT_CHECK, 0, 0);
    send_request(ACT_ALLOC, 0, 0);
    send_request(ACT_CHECK, 1024, 0);
    send_request(ACT_CHECK, 1025, 0);
    send_request(ACT_CHECK, 2047, 10'h3FF);
    send_request(ACT_ALLOC, 1025, 0);
    send_request(ACT_ALLOC, 1024, 0);
    send_request(ACT_ALLOC, 1, 0);
    send_request(ACT_CHECK, 1, 0);
    send_request(ACT_FREE, 0, 0);
    send_request(ACT_FREE, 0, 0);
    send_request(ACT_ALLOC, 100, 0);
    send_request(ACT_ALLOC, 200, 0);
    send_request(ACT_ALLOC, 100, 0);
    send_request(ACT_FREE, 0, 100);
    send_request(ACT_ALLOC, 300, 0);
    send_request(ACT_FREE, 0, 555);
    send_request(ACT_FREE, 0, 0);
    send_request(ACT_FREE, 0, 300);
    send_request(ACT_NONE, 11'h7FF, 10'h3FF);
    // Fill the table with unit segments to reach the full-table case.
    repeat (64) send_request(ACT_ALLOC, 1, 0);
    send_request(ACT_ALLOC, 2, 0);
    send_request(ACT_ALLOC, 1000, 0);
    repeat (90) send_request(ACT_FREE, 0, board.pick_handle());
    repeat (1380) random_request();
    req.valid <= 0;
    feeding_done = 1;
  end

  initial begin
    int gap;
    rsp.ready <= 0;
    @(negedge rst);
    forever begin
      rsp.ready <= 1;
      do @(posedge clk); while (!rsp.valid);
      board.check_response('{status_t'(rsp.status), rsp.granted_offset, rsp.fits,
                             rsp.free_total});
      if ($urandom_range(9, 0) < 5) begin
        gap = gap_length();
        if (gap > 0) begin
          rsp.ready <= 0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  end

  initial begin
    wait (feeding_done);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (board.mismatches == 0 && board.pending.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #20ms;
    $display("Simulation FAILED");
    $finish;
  end
endmodule
